FILE: src/rlpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants of the RGB LED pulse encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

   // Bit slots sent for one pixel: three colour bytes.
   localparam int unsigned BITS_PER_PIXEL = 24;
   localparam int unsigned CHAN_W         = 8;

   // Control register indexes.
   typedef enum logic [1:0] {
      CSR_MAX_BRIGHTNESS = 2'd0,
      CSR_LED_COUNT      = 2'd1,
      CSR_DUTY_ZERO      = 2'd2,
      CSR_DUTY_ONE       = 2'd3
   } csr_index_type;

   // Register values after reset.
   localparam logic [7:0] RST_MAX_BRIGHTNESS = 8'd255;
   localparam logic [7:0] RST_LED_COUNT      = 8'd16;
   localparam logic [7:0] RST_DUTY_ZERO      = 8'd36;
   localparam logic [7:0] RST_DUTY_ONE       = 8'd72;

   // One classified pixel handed from the front end to the serialiser.
   typedef struct packed {
      logic [3:0]                ring;
      logic [BITS_PER_PIXEL-1:0] bits;  // green, red, blue; MSB first
      logic                      tail;  // last pixel of the ring: append gap
   } rlpe_pixel_type;

   // Exact floor(p / 255) for any product p of two 8-bit values (p up to 65025).
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
      return s[15:8];
   endfunction

endpackage

FILE: src/rlpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_queue
// Two-entry queue of classified pixels between the front end and serialiser.
// ----------------------------------------------------------------------------
module rlpe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rlpe_pkg::rlpe_pixel_type push_data,
   output logic                    full,
   input  logic                    pop,
   output rlpe_pkg::rlpe_pixel_type pop_data,
   output logic                    empty
);
   import rlpe_pkg::*;

   rlpe_pixel_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/rlpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_front
// Accepts pixels, drops those out of range and scales the colour channels.
// ----------------------------------------------------------------------------
module rlpe_front #(
   parameter int unsigned NUM_RINGS = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [3:0]               req_ring,
   input  logic [7:0]               req_pixel_index,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               max_brightness,
   input  logic [7:0]               led_count,
   output logic                     q_push,
   output rlpe_pkg::rlpe_pixel_type q_data,
   input  logic                     q_full
);
   import rlpe_pkg::*;

   logic        valid_ff, valid_in;
   logic [3:0]  ring_ff;
   logic        tail_ff;
   logic [15:0] prod_g_ff, prod_r_ff, prod_b_ff;
   logic        accept, in_range;

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;

   // A beat is kept only if its ring and index are both in range.
   assign in_range = ({1'b0, req_ring} < 5'(NUM_RINGS)) && (req_pixel_index < led_count);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = in_range;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Brightness products are registered before the division by 255.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_ff   <= req_ring;
         tail_ff   <= (req_pixel_index == (led_count - 8'd1));
         prod_g_ff <= req_green * max_brightness;
         prod_r_ff <= req_red * max_brightness;
         prod_b_ff <= req_blue * max_brightness;
      end
   end

   // Scaled channels in transmit order.
   always_comb begin
      q_data.ring = ring_ff;
      q_data.tail = tail_ff;
      q_data.bits = {div255(prod_g_ff), div255(prod_r_ff), div255(prod_b_ff)};
   end

endmodule

FILE: src/rlpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_back
// Serialises one pixel into pulse-width words and, after the last pixel of a ring, appends the latch gap.
// ----------------------------------------------------------------------------
module rlpe_back #(
   parameter int unsigned RESET_SLOTS = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rlpe_pkg::rlpe_pixel_type q_data,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  logic [7:0]               duty_zero,
   input  logic [7:0]               duty_one,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [3:0]               rsp_ring_out,
   output logic [7:0]               rsp_duty,
   output logic                     rsp_last
);
   import rlpe_pkg::*;

   localparam int unsigned Slots = BITS_PER_PIXEL + RESET_SLOTS;
   localparam int unsigned CntW  = $clog2(Slots);

   logic                      busy_ff, busy_in;
   logic [3:0]                ring_ff;
   logic                      tail_ff;
   logic [BITS_PER_PIXEL-1:0] shift_ff;
   logic [CntW-1:0]           cnt_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [3:0]                out_ring_ff;
   logic [7:0]                out_duty_ff;
   logic                      out_last_ff;
   logic                      advance, final_word;
   logic [CntW-1:0]           last_idx;
   logic [7:0]                duty_word;

   assign rsp_empty    = !out_valid_ff;
   assign rsp_ring_out = out_ring_ff;
   assign rsp_duty     = out_duty_ff;
   assign rsp_last     = out_last_ff;

   // While a pixel is loaded, a word is produced whenever the output register is free or drains.
   assign advance    = busy_ff && (!out_valid_ff || rsp_pop);
   assign last_idx   = tail_ff ? CntW'(Slots - 1) : CntW'(BITS_PER_PIXEL - 1);
   assign final_word = advance && (cnt_ff == last_idx);
   assign q_pop      = !q_empty && (!busy_ff || final_word);

   // Data slots carry a duty per bit; slots past the data are the gap.
   assign duty_word = (cnt_ff < CntW'(BITS_PER_PIXEL)) ?
                      (shift_ff[BITS_PER_PIXEL-1] ? duty_one : duty_zero) : 8'd0;

   always_comb begin
      busy_in = busy_ff;
      if (q_pop) begin
         busy_in = 1'b1;
      end else if (final_word) begin
         busy_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Current pixel: load from the queue, otherwise step one slot per word.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ring_ff  <= q_data.ring;
         tail_ff  <= q_data.tail;
         shift_ff <= q_data.bits;
         cnt_ff   <= '0;
      end else if (advance) begin
         shift_ff <= {shift_ff[BITS_PER_PIXEL-2:0], 1'b0};
         cnt_ff   <= cnt_ff + CntW'(1);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ring_ff <= ring_ff;
         out_duty_ff <= duty_word;
         out_last_ff <= (cnt_ff == last_idx);
      end
   end

endmodule

FILE: src/rgb_led_pulse_encoder.sv
`timescale 1ns / 1ps
// Path: a pixel beat passes the front-end registers, the two-entry queue, the serialiser's
// pixel register and its output register. One word per cycle while rsp_pop keeps the output
// draining; a pixel gives 24 words, or 24 + RESET_SLOTS when it is the last of its ring.
// Pixels out of range produce nothing and never enter the queue.
// Reset (synchronous, active high) empties the pipeline and restores the registers.
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder
// Turns streamed pixels into pulse-width words for addressable LED rings.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder #(
   parameter int unsigned NUM_RINGS   = 4,
   parameter int unsigned RESET_SLOTS = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_push,
   output logic       req_full,
   input  logic [3:0] req_ring,
   input  logic [7:0] req_pixel_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [3:0] rsp_ring_out,
   output logic [7:0] rsp_duty,
   output logic       rsp_last
);
   import rlpe_pkg::*;

   logic [7:0]     max_brightness_ff, led_count_ff, duty_zero_ff, duty_one_ff;
   logic           q_push, q_full, q_pop, q_empty;
   rlpe_pixel_type q_wdata, q_rdata;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_brightness_ff <= RST_MAX_BRIGHTNESS;
         led_count_ff      <= RST_LED_COUNT;
         duty_zero_ff      <= RST_DUTY_ZERO;
         duty_one_ff       <= RST_DUTY_ONE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_BRIGHTNESS: max_brightness_ff <= csr_wdata;
            CSR_LED_COUNT:      led_count_ff      <= csr_wdata;
            CSR_DUTY_ZERO:      duty_zero_ff      <= csr_wdata;
            CSR_DUTY_ONE:       duty_one_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   rlpe_front #(
      .NUM_RINGS(NUM_RINGS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_ring       (req_ring),
      .req_pixel_index(req_pixel_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .max_brightness (max_brightness_ff),
      .led_count      (led_count_ff),
      .q_push         (q_push),
      .q_data         (q_wdata),
      .q_full         (q_full)
   );

   rlpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .empty    (q_empty)
   );

   rlpe_back #(
      .RESET_SLOTS(RESET_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_data      (q_rdata),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .duty_zero   (duty_zero_ff),
      .duty_one    (duty_one_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_ring_out(rsp_ring_out),
      .rsp_duty    (rsp_duty),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: tb/sv/rgb_led_pulse_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_checker
// Watches the register port and both queue channels of the pulse encoder.
// It keeps its own copy of the registers, turns every pixel beat into the
// words it should cause, and compares each word beat with the oldest one.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder_checker #(
   parameter int unsigned NUM_RINGS   = 4,
   parameter int unsigned RESET_SLOTS = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [3:0] req_ring,
   input  logic [7:0] req_pixel_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [3:0] rsp_ring_out,
   input  logic [7:0] rsp_duty,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         words_pending
);
   import rlpe_pkg::*;

   typedef struct packed {
      logic [3:0] ring;
      logic [7:0] duty;
      logic       last;
   } led_word_type;

   // Shadow copy of the control registers.
   logic [7:0] brightness_cap;
   logic [7:0] ring_length;
   logic [7:0] zero_width;
   logic [7:0] one_width;

   led_word_type pulse_words[$];

   // Brightness scaling with the quotient rounded down.
   function automatic logic [7:0] scale_level(input logic [7:0] level);
      int unsigned product;
      product = 32'(level) * 32'(brightness_cap);
      return 8'(product / 255);
   endfunction

   // Queues the words that one accepted pixel should produce.
   function automatic void encode_pixel(input logic [3:0] ring, input logic [7:0] index,
                                        input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue);
      logic [BITS_PER_PIXEL-1:0] bits;
      led_word_type              word;
      logic                      tail;
      int                        total;
      if (ring >= NUM_RINGS || index >= ring_length) return;
      bits  = {scale_level(green), scale_level(red), scale_level(blue)};
      tail  = (index == ring_length - 8'd1);
      total = tail ? BITS_PER_PIXEL + RESET_SLOTS : BITS_PER_PIXEL;
      for (int n = 0; n < total; n++) begin
         word.ring = ring;
         // The latch gap after the last pixel of a ring is all zero words.
         if (n >= BITS_PER_PIXEL) word.duty = 8'd0;
         else word.duty = bits[BITS_PER_PIXEL-1-n] ? one_width : zero_width;
         word.last = (n == total - 1);
         pulse_words.push_back(word);
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      led_word_type want;
      if (reset) begin
         brightness_cap = RST_MAX_BRIGHTNESS;
         ring_length    = RST_LED_COUNT;
         zero_width     = RST_DUTY_ZERO;
         one_width      = RST_DUTY_ONE;
         pulse_words.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_BRIGHTNESS: brightness_cap = csr_wdata;
               CSR_LED_COUNT:      ring_length    = csr_wdata;
               CSR_DUTY_ZERO:      zero_width     = csr_wdata;
               CSR_DUTY_ONE:       one_width      = csr_wdata;
               default: ;
            endcase
         end

         // A word beat is compared before any pixel beat of the same edge is
         // expanded, as a pixel cannot reach the output in the cycle it enters.
         if (rsp_pop && !rsp_empty) begin
            if (pulse_words.size() == 0) begin
               $error("unexpected word: ring_out %0d, duty %0d, last %0d",
                      rsp_ring_out, rsp_duty, rsp_last);
               mismatch_count++;
            end else begin
               want = pulse_words.pop_front();
               if (rsp_ring_out !== want.ring) begin
                  $error("ring_out: expected %0d, actual %0d", want.ring, rsp_ring_out);
                  mismatch_count++;
               end
               if (rsp_duty !== want.duty) begin
                  $error("duty: expected %0d, actual %0d", want.duty, rsp_duty);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end

         if (req_push && !req_full)
            encode_pixel(req_ring, req_pixel_index, req_red, req_green, req_blue);
      end
      words_pending = pulse_words.size();
   end

endmodule

FILE: tb/sv/rgb_led_pulse_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_tb
// Drives pixels and register writes into the pulse encoder and gives the
// verdict. A directed run covers the range limits, the latch gap and the
// register extremes; random pixels follow under changing idle patterns,
// with a long output stall and drain pauses between settings.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder_tb;
   import rlpe_pkg::*;

   localparam int unsigned LED_RINGS      = 4;
   localparam int unsigned GAP_SLOTS      = 40;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          BATCH_ITEMS    = 26;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   logic       req_push;
   logic       req_full;
   logic [3:0] req_ring;
   logic [7:0] req_pixel_index;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [3:0] rsp_ring_out;
   logic [7:0] rsp_duty;
   logic       rsp_last;

   int         mismatch_count;
   int         words_pending;
   int         tx_idle_pct;
   int         rx_idle_pct;
   int         hold_left;
   int         quiet_cycles;
   logic [7:0] led_count_now;

   rgb_led_pulse_encoder #(
      .NUM_RINGS   (LED_RINGS),
      .RESET_SLOTS (GAP_SLOTS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ring        (req_ring),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_ring_out    (rsp_ring_out),
      .rsp_duty        (rsp_duty),
      .rsp_last        (rsp_last)
   );

   rgb_led_pulse_encoder_checker #(
      .NUM_RINGS   (LED_RINGS),
      .RESET_SLOTS (GAP_SLOTS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ring        (req_ring),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_ring_out    (rsp_ring_out),
      .rsp_duty        (rsp_duty),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Output side: random pops, or a long hold-off when one is requested.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_pop = 1'b0;
            hold_left--;
         end else begin
            rsp_pop = ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Ends the run when nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one pixel after a random gap and returns once the beat is taken.
   task automatic send_pixel(input logic [3:0] ring, input logic [7:0] index,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push        = 1'b1;
      req_ring        = ring;
      req_pixel_index = index;
      req_red         = red;
      req_green       = green;
      req_blue        = blue;
      do @(posedge clock); while (req_full);
   endtask

   task automatic stop_pushing();
      @(negedge clock);
      req_push = 1'b0;
   endtask

   // Waits for every expected word, then for any range-rejected pixel still
   // in the pipeline to clear before the registers may change.
   task automatic wait_until_drained();
      stop_pushing();
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_reg(input csr_index_type index, input logic [7:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      if (index == CSR_LED_COUNT) led_count_now = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic program_setting(input logic [7:0] brightness, input logic [7:0] length,
                                  input logic [7:0] zero_width, input logic [7:0] one_width);
      program_reg(CSR_MAX_BRIGHTNESS, brightness);
      program_reg(CSR_LED_COUNT, length);
      program_reg(CSR_DUTY_ZERO, zero_width);
      program_reg(CSR_DUTY_ONE, one_width);
   endtask

   // Colour bytes lean towards the extremes now and then.
   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] random_length();
      case ($urandom_range(0, 5))
         0:       return 8'd1;
         1:       return 8'd255;
         default: return 8'($urandom_range(2, 8));
      endcase
   endfunction

   task automatic program_random_setting();
      program_setting(random_level(), random_length(), random_level(), random_level());
   endtask

   // Mostly pixels in range, with the last index of the ring favoured so the
   // latch gap comes up often; the rest is out-of-range noise.
   task automatic send_random_pixel();
      logic [3:0] ring;
      logic [7:0] index;
      if ($urandom_range(0, 99) < 15 || led_count_now == 8'd0) begin
         ring  = 4'($urandom_range(0, 15));
         index = 8'($urandom_range(0, 255));
      end else begin
         ring = 4'($urandom_range(0, LED_RINGS - 1));
         if ($urandom_range(0, 2) == 0) index = led_count_now - 8'd1;
         else index = 8'($urandom_range(0, led_count_now - 1));
      end
      send_pixel(ring, index, random_level(), random_level(), random_level());
   endtask

   task automatic run_random_phase(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (3) begin
         wait_until_drained();
         program_random_setting();
         repeat (BATCH_ITEMS) send_random_pixel();
      end
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_MAX_BRIGHTNESS;
      csr_wdata       = 8'd0;
      req_push        = 1'b0;
      req_ring        = 4'd0;
      req_pixel_index = 8'd0;
      req_red         = 8'd0;
      req_green       = 8'd0;
      req_blue        = 8'd0;
      tx_idle_pct     = 20;
      rx_idle_pct     = 83;
      hold_left       = 0;
      quiet_cycles    = 0;
      led_count_now   = RST_LED_COUNT;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Registers as they come out of reset: edges of the ring and index range.
      send_pixel(4'd0, 8'd0, 8'h00, 8'h00, 8'h00);
      send_pixel(4'd3, 8'd15, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(4'd1, 8'd7, 8'hAA, 8'h55, 8'h0F);
      send_pixel(4'd2, 8'd15, 8'h80, 8'h01, 8'h7F);
      send_pixel(4'd4, 8'd0, 8'h11, 8'h22, 8'h33);
      send_pixel(4'd15, 8'd255, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(4'd0, 8'd16, 8'h44, 8'h55, 8'h66);
      send_pixel(4'd1, 8'd0, 8'h01, 8'h80, 8'hFE);

      // Zero brightness on a one-pixel ring: every data word is the zero width.
      wait_until_drained();
      program_setting(8'd0, 8'd1, 8'd255, 8'd0);
      send_pixel(4'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(4'd3, 8'd1, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(4'd2, 8'd255, 8'h00, 8'h00, 8'h00);

      // Half brightness on the longest ring.
      wait_until_drained();
      program_setting(8'd128, 8'd255, 8'd0, 8'd255);
      send_pixel(4'd1, 8'd254, 8'hFF, 8'h80, 8'h01);
      send_pixel(4'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(4'd3, 8'd100, 8'h7F, 8'hC3, 8'h3C);

      // A zero LED count rejects every pixel.
      wait_until_drained();
      program_reg(CSR_LED_COUNT, 8'd0);
      send_pixel(4'd0, 8'd0, 8'hFF, 8'h00, 8'hFF);
      send_pixel(4'd2, 8'd255, 8'h00, 8'hFF, 8'h00);

      wait_until_drained();
      program_setting(8'd255, 8'd2, 8'd36, 8'd72);
      send_pixel(4'd0, 8'd1, 8'hFF, 8'h00, 8'hFF);
      send_pixel(4'd3, 8'd0, 8'h12, 8'h34, 8'h56);
      send_pixel(4'd3, 8'd1, 8'h9A, 8'hBC, 8'hDE);

      run_random_phase(20, 83);
      run_random_phase(83, 20);
      run_random_phase(0, 0);

      // Hold the output off while pixels keep coming so the input backs up.
      wait_until_drained();
      program_random_setting();
      hold_left = HOLD_CYCLES;
      repeat (10) send_random_pixel();

      wait_until_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
src/rlpe_pkg.sv
src/rlpe_queue.sv
src/rlpe_front.sv
src/rlpe_back.sv
src/rgb_led_pulse_encoder.sv
tb/sv/rgb_led_pulse_encoder_checker.sv
tb/sv/rgb_led_pulse_encoder_tb.sv
